@@ rtl/edist_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// edist_pkg: shared types and constants of the edit distance engine
// Beat formats, command codes and store geometry.
// ----------------------------------------------------------------------------
package edist_pkg;

	localparam int MAX_CHARS = 128;

	localparam int LEN_W  = $clog2(MAX_CHARS + 1);
	localparam int FS_AW  = $clog2(MAX_CHARS);
	localparam int ROW_AW = $clog2(MAX_CHARS + 1);
	localparam int CH_W   = 8;
	localparam int COST_W = 8;

	localparam logic [1:0] CMD_FIRST  = 2'd0;
	localparam logic [1:0] CMD_SECOND = 2'd1;
	localparam logic [1:0] CMD_FINISH = 2'd2;
	localparam logic [1:0] CMD_UNUSED = 2'd3;

	typedef struct packed {
		logic [1:0]      cmd;
		logic [CH_W-1:0] ch;
	} item_beat_t;

	typedef struct packed {
		logic [7:0] distance;
		logic       overflow;
	} result_beat_t;

	typedef enum logic [3:0] {
		S_IDLE  = 4'b0001,
		S_START = 4'b0010,
		S_RUN   = 4'b0100,
		S_FIN   = 4'b1000
	} state_t;

endpackage
`default_nettype wire

@@ rtl/edist_ram.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// edist_ram: generic single-write, single-read RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module edist_ram #(
	parameter int  WIDTH = 8,
	parameter int  DEPTH = 128,
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic             re,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule
`default_nettype wire

@@ rtl/edit_distance_engine_core.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// edit_distance_engine_core: Levenshtein edit distance between two byte strings
// Stores the first string, updates one table row per second-string byte with
// a single cell unit, and emits the distance on a finish command.
// ----------------------------------------------------------------------------
//   channel  | ports                              | beat
//   ---------+------------------------------------+---------------------------
//   item     | item_valid, item_stall, item       | cmd, ch
//   result   | result_valid, result_stall, result | distance, overflow
//
// First-string bytes and unused commands stay in idle. A second-string byte
// passes the start state and, if first_length is nonzero, the run state, one
// cell per cycle. A finish waits in the finish state for the output register.
// Reset clears lengths, flag and output valid; the two RAMs are not cleared.
// item_stall is high while the sequencer is busy; a result held in the output
// register does not block first- or second-string bytes.
// ----------------------------------------------------------------------------
module edit_distance_engine_core (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     item_valid,
	output logic                          item_stall,
	input  wire edist_pkg::item_beat_t    item,
	output logic                          result_valid,
	input  wire logic                     result_stall,
	output edist_pkg::result_beat_t       result
);

	import edist_pkg::*;

	state_t              state_q;
	logic [LEN_W-1:0]    fl_q;
	logic [LEN_W-1:0]    sl_q;
	logic                ovf_q;
	logic                result_valid_q;
	result_beat_t        result_q;
	logic [CH_W-1:0]     ch_q;
	logic [LEN_W-1:0]    i_q;
	logic [COST_W-1:0]   diag_q;
	logic [COST_W-1:0]   left_q;

	logic                accept;
	logic                out_free;
	logic                fresh;
	logic                fs_we;
	logic                fs_re;
	logic [FS_AW-1:0]    fs_raddr;
	logic [CH_W-1:0]     fs_rdata;
	logic                row_we;
	logic [ROW_AW-1:0]   row_waddr;
	logic [COST_W-1:0]   row_wdata;
	logic                row_re;
	logic [ROW_AW-1:0]   row_raddr;
	logic [COST_W-1:0]   row_rdata;
	logic [COST_W-1:0]   up;
	logic [COST_W-1:0]   min_ab;
	logic [COST_W-1:0]   min_abc;
	logic [COST_W-1:0]   cell_cost;
	logic [LEN_W-1:0]    sl_inc;

	assign item_stall   = (state_q != S_IDLE);
	assign accept       = item_valid && !item_stall;
	assign out_free     = !result_valid_q || !result_stall;
	assign fresh        = (sl_q == '0);
	assign sl_inc       = LEN_W'(sl_q + 1'b1);
	assign result_valid = result_valid_q;
	assign result       = result_q;

	assign fs_we = accept && (item.cmd == CMD_FIRST) && fresh
		&& (fl_q < LEN_W'(MAX_CHARS));

	// shared cell unit
	assign up        = fresh ? COST_W'(i_q) : row_rdata;
	assign min_ab    = (diag_q < up) ? diag_q : up;
	assign min_abc   = (min_ab < left_q) ? min_ab : left_q;
	assign cell_cost = (fs_rdata == ch_q) ? diag_q : COST_W'(min_abc + 1'b1);

	always_comb begin
		fs_re     = 1'b0;
		fs_raddr  = '0;
		row_we    = 1'b0;
		row_waddr = '0;
		row_wdata = cell_cost;
		row_re    = 1'b0;
		row_raddr = '0;
		unique case (state_q)
			S_IDLE: begin
				if (accept && (item.cmd == CMD_SECOND)) begin
					row_re = 1'b1;
				end else if (accept && (item.cmd == CMD_FINISH)) begin
					row_re    = 1'b1;
					row_raddr = ROW_AW'(fl_q);
				end
			end
			S_START: begin
				row_we    = 1'b1;
				row_wdata = COST_W'(sl_inc);
				row_re    = (fl_q != '0);
				row_raddr = ROW_AW'(1);
				fs_re     = (fl_q != '0);
			end
			S_RUN: begin
				row_we    = 1'b1;
				row_waddr = ROW_AW'(i_q);
				row_re    = (i_q != fl_q);
				row_raddr = ROW_AW'(i_q + 1'b1);
				fs_re     = (i_q != fl_q);
				fs_raddr  = i_q[FS_AW-1:0];
			end
			S_FIN: begin
			end
			default: begin
			end
		endcase
	end

	edist_ram #(
		.WIDTH(CH_W),
		.DEPTH(MAX_CHARS)
	) u_first_ram (
		.clk   (clk),
		.we    (fs_we),
		.waddr (fl_q[FS_AW-1:0]),
		.wdata (item.ch),
		.re    (fs_re),
		.raddr (fs_raddr),
		.rdata (fs_rdata)
	);

	edist_ram #(
		.WIDTH(COST_W),
		.DEPTH(MAX_CHARS + 1)
	) u_row_ram (
		.clk   (clk),
		.we    (row_we),
		.waddr (row_waddr),
		.wdata (row_wdata),
		.re    (row_re),
		.raddr (row_raddr),
		.rdata (row_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= S_IDLE;
			fl_q           <= '0;
			sl_q           <= '0;
			ovf_q          <= 1'b0;
			result_valid_q <= 1'b0;
		end else begin
			if (result_valid_q && !result_stall && (state_q != S_FIN)) begin
				result_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						case (item.cmd)
							CMD_FIRST: begin
								if (fresh) begin
									if (fl_q < LEN_W'(MAX_CHARS)) begin
										fl_q <= LEN_W'(fl_q + 1'b1);
									end else begin
										ovf_q <= 1'b1;
									end
								end
							end
							CMD_SECOND: begin
								if (sl_q < LEN_W'(MAX_CHARS)) begin
									state_q <= S_START;
								end else begin
									ovf_q <= 1'b1;
								end
							end
							CMD_FINISH: begin
								state_q <= S_FIN;
							end
							default: begin
							end
						endcase
					end
				end
				S_START: begin
					if (fl_q == '0) begin
						sl_q    <= sl_inc;
						state_q <= S_IDLE;
					end else begin
						state_q <= S_RUN;
					end
				end
				S_RUN: begin
					if (i_q == fl_q) begin
						sl_q    <= sl_inc;
						state_q <= S_IDLE;
					end
				end
				S_FIN: begin
					if (out_free) begin
						result_valid_q <= 1'b1;
						fl_q           <= '0;
						sl_q           <= '0;
						ovf_q          <= 1'b0;
						state_q        <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			ch_q <= item.ch;
		end
		if (state_q == S_START) begin
			diag_q <= fresh ? '0 : row_rdata;
			left_q <= COST_W'(sl_inc);
			i_q    <= LEN_W'(1);
		end
		if (state_q == S_RUN) begin
			diag_q <= up;
			left_q <= cell_cost;
			i_q    <= LEN_W'(i_q + 1'b1);
		end
		if ((state_q == S_FIN) && out_free) begin
			result_q.distance <= fresh ? 8'(fl_q) : 8'(row_rdata);
			result_q.overflow <= ovf_q;
		end
	end

endmodule
`default_nettype wire
